/* sv/lfug_pkg.sv */
// lfug_pkg: constants and shared types for the lagged-fibonacci uniform generator
// used by lfug_seed and lagged_fibonacci_uniform_generator_top; no dependencies
`default_nettype none

package lfug_pkg;

  localparam int TABLE_DEPTH   = 97;
  localparam int FRACTION_BITS = 24;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int SEED_W        = 15;
  localparam int CFG_INDEX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_SECOND = 2'd1;

  localparam logic [SEED_W-1:0] SEED_FIRST_RESET  = 15'd2003;
  localparam logic [SEED_W-1:0] SEED_SECOND_RESET = 15'd1225;
  localparam logic [SEED_W-1:0] SEED_FIRST_MAX    = 15'd31328;
  localparam logic [SEED_W-1:0] SEED_SECOND_MAX   = 15'd30081;
  localparam logic [SEED_W-1:0] SEED_FIRST_DFLT   = 15'd1802;
  localparam logic [SEED_W-1:0] SEED_SECOND_DFLT  = 15'd9373;

  // lag positions, stored zero based
  localparam int SHORT_LAG = 33;
  localparam logic [ADDR_W-1:0] LONG_START  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] SHORT_START = ADDR_W'(SHORT_LAG - 1);

  localparam logic [FRACTION_BITS-1:0] CARRY_INIT = 24'd362436;
  localparam logic [FRACTION_BITS-1:0] CARRY_STEP = 24'd7654321;
  localparam logic [FRACTION_BITS-1:0] CARRY_MOD  = 24'd16777213;
  localparam logic [FRACTION_BITS-1:0] CARRY_WRAP = CARRY_MOD - CARRY_STEP;

  // small moduli of the seeding sequence
  localparam logic [15:0] MOD_177 = 16'd177;
  localparam logic [15:0] MOD_169 = 16'd169;
  localparam logic [15:0] MOD_179 = 16'd179;
  localparam logic [15:0] MUL_53  = 16'd53;

  // ceil(2^22 / d): quotient is exact for every operand the walk produces
  localparam int RECIP_SHIFT = 22;
  localparam logic [29:0] RECIP_177 = 30'd23697;
  localparam logic [29:0] RECIP_169 = 30'd24819;
  localparam logic [29:0] RECIP_179 = 30'd23432;

  typedef struct packed {
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [FRACTION_BITS-1:0] wr_data;
    logic                     done;
  } lfug_seed_out_t;

endpackage

`default_nettype wire

/* sv/lagged_fibonacci_uniform_generator_top.sv */
// a fraction draw passes ST_CALC then ST_OUT; a range draw adds ST_MLO, ST_MHI and ST_SUM;
// equal bounds go straight to ST_OUT; a new request is taken only once back in ST_IDLE;
//   the table memory is read at two addresses and written once per draw
// first draw after reset or a seed write adds the table walk: 97 x 24 steps
// reset: seeds 2003 / 1225, carry and lag positions initial, table unseeded
`default_nettype none

module lagged_fibonacci_uniform_generator_top import lfug_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [SEED_W-1:0]               cfg_data,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            kind,
  input  logic signed [31:0]              range_low,
  input  logic signed [31:0]              range_high,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [FRACTION_BITS-1:0]        fraction,
  output logic signed [31:0]              int_value,
  output logic                            drew
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEED, ST_RD, ST_CALC, ST_MLO, ST_MHI, ST_SUM, ST_OUT
  } state_t;

  state_t                   state;
  logic [SEED_W-1:0]        seed_first;
  logic [SEED_W-1:0]        seed_second;
  logic                     seeded;
  logic [FRACTION_BITS-1:0] carry;
  logic [ADDR_W-1:0]        long_addr;
  logic [ADDR_W-1:0]        short_addr;

  logic                     kind_r;
  logic signed [31:0]       lo_r;
  logic signed [31:0]       hi_r;
  logic [32:0]              span_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic                     drew_r;
  logic [39:0]              plo_r;
  logic [40:0]              phi_r;
  logic [31:0]              off_r;

  logic [FRACTION_BITS-1:0] lag_mem [TABLE_DEPTH];
  logic [FRACTION_BITS-1:0] x_q;
  logic [FRACTION_BITS-1:0] y_q;

  lfug_seed_out_t           seed_out;

  logic                     accept;
  logic                     needs_draw;
  logic                     seed_start;
  logic                     step_now;
  logic                     slot_free;
  logic [FRACTION_BITS-1:0] carry_next;
  logic [FRACTION_BITS-1:0] diff;
  logic [FRACTION_BITS-1:0] frac;
  logic                     mem_wr_en;
  logic [ADDR_W-1:0]        mem_wr_addr;
  logic [FRACTION_BITS-1:0] mem_wr_data;
  logic [56:0]              prod_sum;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    accept     = req_valid & req_ready;
    needs_draw = !kind || (range_low != range_high);
    seed_start = accept && needs_draw && !seeded;
    // carry steps on the cycle the two table reads go out
    step_now   = (accept && needs_draw && seeded) || (state == ST_RD);
    slot_free  = !rsp_valid || rsp_ready;
    carry_next = (carry >= CARRY_STEP) ? carry - CARRY_STEP : carry + CARRY_WRAP;

    // subtraction modulo 1 is plain wraparound in 24 bits
    diff = x_q - y_q;
    frac = diff - carry;

    mem_wr_en   = seed_out.wr_en || (state == ST_CALC);
    mem_wr_addr = seed_out.wr_en ? seed_out.wr_addr : long_addr;
    mem_wr_data = seed_out.wr_en ? seed_out.wr_data : diff;

    prod_sum = (57'(phi_r) << 16) + 57'(plo_r);
  end

  lfug_seed u_seed (
    .clk      (clk),
    .rst      (rst),
    .start    (seed_start),
    .seed_a   (seed_first),
    .seed_b   (seed_second),
    .seed_out (seed_out)
  );

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      lag_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (step_now) begin
      x_q <= lag_mem[long_addr];
      y_q <= lag_mem[short_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seed_first  <= SEED_FIRST_RESET;
      seed_second <= SEED_SECOND_RESET;
      seeded      <= 1'b0;
      carry       <= CARRY_INIT;
      long_addr   <= LONG_START;
      short_addr  <= SHORT_START;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEED_FIRST: begin
            seed_first <= cfg_data;
            seeded     <= 1'b0;
          end
          CFG_SEED_SECOND: begin
            seed_second <= cfg_data;
            seeded      <= 1'b0;
          end
          default: ;
        endcase
      end

      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (step_now) begin
        carry <= carry_next;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_r <= kind;
            if (range_low > range_high) begin
              lo_r <= range_high;
              hi_r <= range_low;
            end else begin
              lo_r <= range_low;
              hi_r <= range_high;
            end
            frac_r <= '0;
            drew_r <= 1'b0;
            off_r  <= '0;
            if (!needs_draw) begin
              state <= ST_OUT;
            end else if (!seeded) begin
              state <= ST_SEED;
            end else begin
              state <= ST_CALC;
            end
          end
        end
        ST_SEED: begin
          if (seed_out.done) begin
            seeded     <= 1'b1;
            carry      <= CARRY_INIT;
            long_addr  <= LONG_START;
            short_addr <= SHORT_START;
            state      <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          frac_r     <= frac;
          drew_r     <= 1'b1;
          span_r     <= {hi_r[31], hi_r} - {lo_r[31], lo_r} + 33'd1;
          long_addr  <= (long_addr == '0) ? LONG_START : long_addr - 1'b1;
          short_addr <= (short_addr == '0) ? LONG_START : short_addr - 1'b1;
          state      <= kind_r ? ST_MLO : ST_OUT;
        end
        // fraction times span split into two partial products
        ST_MLO: begin
          plo_r <= 40'(frac_r) * 40'(span_r[15:0]);
          state <= ST_MHI;
        end
        ST_MHI: begin
          phi_r <= 41'(frac_r) * 41'(span_r[32:16]);
          state <= ST_SUM;
        end
        ST_SUM: begin
          off_r <= 32'(prod_sum >> FRACTION_BITS);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            fraction  <= frac_r;
            int_value <= kind_r ? lo_r + off_r : '0;
            drew      <= drew_r;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/lfug_seed.sv */
// lfug_seed: table fill walk, one 24-bit word per 24 sequence steps (S_P1 through S_BIT)
// depends on lfug_pkg
`default_nettype none

module lfug_seed import lfug_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SEED_W-1:0]     seed_a,
  input  logic [SEED_W-1:0]     seed_b,
  output lfug_seed_out_t        seed_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_INIT, S_P1, S_Q1, S_R1, S_P2, S_Q2, S_R2, S_BIT
  } state_t;

  state_t                   state;
  logic [SEED_W-1:0]        a_r;
  logic [SEED_W-1:0]        b_r;
  logic [7:0]               qa;
  logic [7:0]               qb;
  logic [7:0]               i_r;
  logic [7:0]               j_r;
  logic [7:0]               k_r;
  logic [7:0]               l_r;
  logic [7:0]               m_r;
  logic [7:0]               rem_r;
  logic [7:0]               q_r;
  logic [7:0]               ql_r;
  logic [15:0]              prod_r;
  logic [13:0]              tl_r;
  logic [4:0]               bit_cnt;
  logic [ADDR_W-1:0]        word_cnt;
  logic [FRACTION_BITS-1:0] acc;

  logic                     use_default;
  logic [29:0]              qa_prod;
  logic [29:0]              qb_prod;
  logic [29:0]              q_prod;
  logic [29:0]              ql_prod;
  logic [15:0]              ra_raw;
  logic [15:0]              rb_raw;
  logic [7:0]               qa_fix;
  logic [7:0]               qb_fix;
  logic [7:0]               ra_fix;
  logic [7:0]               rb_fix;
  logic [15:0]              r_raw;
  logic [7:0]               r_fix;
  logic [15:0]              lraw;
  logic [7:0]               l_fix;
  logic [15:0]              lm;
  logic [FRACTION_BITS-1:0] acc_next;

  always_comb begin
    use_default = (seed_a > SEED_FIRST_MAX) || (seed_b > SEED_SECOND_MAX);

    qa_prod = 30'(a_r) * RECIP_177;
    qb_prod = 30'(b_r) * RECIP_169;
    q_prod  = 30'(prod_r) * RECIP_179;
    ql_prod = 30'(tl_r) * RECIP_169;

    // remainders with a single guard subtract
    ra_raw = 16'(a_r) - 16'(qa) * MOD_177;
    rb_raw = 16'(b_r) - 16'(qb) * MOD_169;
    if (ra_raw >= MOD_177) begin
      qa_fix = qa + 8'd1;
      ra_fix = 8'(ra_raw - MOD_177);
    end else begin
      qa_fix = qa;
      ra_fix = 8'(ra_raw);
    end
    if (rb_raw >= MOD_169) begin
      qb_fix = qb + 8'd1;
      rb_fix = 8'(rb_raw - MOD_169);
    end else begin
      qb_fix = qb;
      rb_fix = 8'(rb_raw);
    end

    r_raw = prod_r - 16'(q_r) * MOD_179;
    r_fix = (r_raw >= MOD_179) ? 8'(r_raw - MOD_179) : 8'(r_raw);
    lraw  = 16'(tl_r) - 16'(ql_r) * MOD_169;
    l_fix = (lraw >= MOD_169) ? 8'(lraw - MOD_169) : 8'(lraw);

    // output bit is bit 5 of (l * m) mod 64
    lm       = 16'(l_r) * 16'(m_r);
    acc_next = {acc[FRACTION_BITS-2:0], lm[5]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      seed_out.wr_en <= 1'b0;
      seed_out.done  <= 1'b0;
    end else begin
      seed_out.wr_en <= 1'b0;
      seed_out.done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            a_r   <= use_default ? SEED_FIRST_DFLT : seed_a;
            b_r   <= use_default ? SEED_SECOND_DFLT : seed_b;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          qa    <= 8'(qa_prod >> RECIP_SHIFT);
          qb    <= 8'(qb_prod >> RECIP_SHIFT);
          state <= S_INIT;
        end
        S_INIT: begin
          i_r      <= qa_fix + 8'd2;
          j_r      <= ra_fix + 8'd2;
          k_r      <= qb_fix + 8'd1;
          l_r      <= rb_fix;
          bit_cnt  <= '0;
          word_cnt <= '0;
          acc      <= '0;
          state    <= S_P1;
        end
        S_P1: begin
          prod_r <= 16'(i_r) * 16'(j_r);
          tl_r   <= 14'(MUL_53 * 16'(l_r) + 16'd1);
          state  <= S_Q1;
        end
        S_Q1: begin
          q_r   <= 8'(q_prod >> RECIP_SHIFT);
          ql_r  <= 8'(ql_prod >> RECIP_SHIFT);
          state <= S_R1;
        end
        S_R1: begin
          rem_r <= r_fix;
          l_r   <= l_fix;
          state <= S_P2;
        end
        S_P2: begin
          prod_r <= 16'(rem_r) * 16'(k_r);
          state  <= S_Q2;
        end
        S_Q2: begin
          q_r   <= 8'(q_prod >> RECIP_SHIFT);
          state <= S_R2;
        end
        S_R2: begin
          m_r   <= r_fix;
          state <= S_BIT;
        end
        S_BIT: begin
          i_r <= j_r;
          j_r <= k_r;
          k_r <= m_r;
          acc <= acc_next;
          if (bit_cnt == 5'(FRACTION_BITS - 1)) begin
            seed_out.wr_en   <= 1'b1;
            seed_out.wr_addr <= word_cnt;
            seed_out.wr_data <= acc_next;
            bit_cnt          <= '0;
            if (word_cnt == ADDR_W'(TABLE_DEPTH - 1)) begin
              seed_out.done <= 1'b1;
              state         <= S_IDLE;
            end else begin
              word_cnt <= word_cnt + 1'b1;
              state    <= S_P1;
            end
          end else begin
            bit_cnt <= bit_cnt + 1'b1;
            state   <= S_P1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
